>>> rtl/core/wcs_pkg.sv
// ----------------------------------------------------------------------------
// wcs_pkg
// Shared types, constants and lookup functions of the wash cycle sequencer.
// ----------------------------------------------------------------------------
package wcs_pkg;

	localparam int TEMP_W     = 10;
	localparam int TPS_W      = 10;
	localparam int BTN_W      = 3;
	localparam int PHASE_W    = 3;
	localparam int PROG_W     = 2;
	localparam int SECS_W     = 4;
	localparam int CFG_W      = 10;
	localparam int CFG_IDX_W  = 1;
	localparam int COUNT_BITS_DEF = 14;

	localparam logic [CFG_IDX_W-1:0] CFG_TEMP_THRESHOLD   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_SECOND = 1'd1;

	localparam logic [TEMP_W-1:0] TEMP_THRESHOLD_RST   = 10'd160;
	localparam logic [TPS_W-1:0]  TICKS_PER_SECOND_RST = 10'd10;

	localparam logic [PHASE_W-1:0] PHASE_CODE_IDLE  = 3'd0;
	localparam logic [PHASE_W-1:0] PHASE_CODE_FILL  = 3'd1;
	localparam logic [PHASE_W-1:0] PHASE_CODE_WASH  = 3'd2;
	localparam logic [PHASE_W-1:0] PHASE_CODE_DRY   = 3'd3;
	localparam logic [PHASE_W-1:0] PHASE_CODE_DRAIN = 3'd4;

	localparam logic [PROG_W-1:0] PROG_NONE = 2'd0;
	localparam logic [PROG_W-1:0] PROG_1    = 2'd1;
	localparam logic [PROG_W-1:0] PROG_2    = 2'd2;
	localparam logic [PROG_W-1:0] PROG_3    = 2'd3;

	typedef enum logic [4:0] {
		PH_IDLE  = 5'b00001,
		PH_FILL  = 5'b00010,
		PH_WASH  = 5'b00100,
		PH_DRY   = 5'b01000,
		PH_DRAIN = 5'b10000
	} phase_t;

	typedef struct packed {
		logic              door_closed;
		logic [TEMP_W-1:0] temperature;
		logic [BTN_W-1:0]  program_buttons;
	} tick_t;

	typedef struct packed {
		logic valid;
		logic advance;
	} stage_ctl_t;

	function automatic logic [PHASE_W-1:0] phase_code(input phase_t ph);
		logic [PHASE_W-1:0] c;
		unique case (ph)
			PH_FILL:  c = PHASE_CODE_FILL;
			PH_WASH:  c = PHASE_CODE_WASH;
			PH_DRY:   c = PHASE_CODE_DRY;
			PH_DRAIN: c = PHASE_CODE_DRAIN;
			default:  c = PHASE_CODE_IDLE;
		endcase
		return c;
	endfunction

	function automatic phase_t next_phase(input phase_t ph);
		phase_t n;
		unique case (ph)
			PH_FILL: n = PH_WASH;
			PH_WASH: n = PH_DRY;
			PH_DRY:  n = PH_DRAIN;
			default: n = PH_IDLE;
		endcase
		return n;
	endfunction

	// phase seconds, fill/wash/dry/drain
	function automatic logic [SECS_W-1:0] phase_secs(input logic [PROG_W-1:0] prog,
		input phase_t ph);
		logic [SECS_W-1:0] s;
		s = '0;
		unique case (prog)
			PROG_1: begin
				unique case (ph)
					PH_FILL:  s = 4'd1;
					PH_WASH:  s = 4'd10;
					PH_DRY:   s = 4'd5;
					PH_DRAIN: s = 4'd1;
					default:  s = 4'd0;
				endcase
			end
			PROG_2: begin
				unique case (ph)
					PH_FILL:  s = 4'd1;
					PH_WASH:  s = 4'd5;
					PH_DRY:   s = 4'd2;
					PH_DRAIN: s = 4'd3;
					default:  s = 4'd0;
				endcase
			end
			PROG_3: begin
				unique case (ph)
					PH_FILL:  s = 4'd1;
					PH_WASH:  s = 4'd5;
					PH_DRY:   s = 4'd3;
					PH_DRAIN: s = 4'd1;
					default:  s = 4'd0;
				endcase
			end
			default: s = 4'd0;
		endcase
		return s;
	endfunction

endpackage

>>> rtl/core/wcs_tick_if.sv
// ----------------------------------------------------------------------------
// wcs_tick_if
// Tick channel: one item per time tick with door, temperature and buttons.
// ----------------------------------------------------------------------------
interface wcs_tick_if;
	import wcs_pkg::*;

	logic              valid;
	logic              ready;
	logic              door_closed;
	logic [TEMP_W-1:0] temperature;
	logic [BTN_W-1:0]  program_buttons;

	modport source (output valid, output door_closed, output temperature,
		output program_buttons, input ready);
	modport sink (input valid, input door_closed, input temperature,
		input program_buttons, output ready);
endinterface

>>> rtl/core/wcs_result_if.sv
// ----------------------------------------------------------------------------
// wcs_result_if
// Result channel: phase, fault flag, drive outputs and completion pulse.
// ----------------------------------------------------------------------------
interface wcs_result_if;
	import wcs_pkg::*;

	logic               valid;
	logic               ready;
	logic [PHASE_W-1:0] phase;
	logic               fault;
	logic               fill_valve;
	logic               motor_on;
	logic               drain_valve;
	logic               cycle_done;

	modport source (output valid, output phase, output fault, output fill_valve,
		output motor_on, output drain_valve, output cycle_done, input ready);
	modport sink (input valid, input phase, input fault, input fill_valve,
		input motor_on, input drain_valve, input cycle_done, output ready);
endinterface

>>> rtl/core/appliance_wash_cycle_sequencer.sv
// ----------------------------------------------------------------------------
// appliance_wash_cycle_sequencer
// Wash cycle sequencer: fill, wash, dry and drain timed in ticks, with
// fault abort on door open or low temperature.
// ----------------------------------------------------------------------------
//  channel   dir  payload
//  tick      in   door_closed, temperature, program_buttons
//  result    out  phase, fault, fill_valve, motor_on, drain_valve, cycle_done
//  cfg       in   cfg_we, cfg_index, cfg_wdata (write only)
//
// One item per cycle sustained while result is not stalled; a tick passes
// the input register, then the state update into the result register.
// Phase state and tick countdown update together as each item advances.
// Reset: idle phase, counters cleared, registers at defaults; no sweep.
// tick.ready drops only while both stages hold items and result is stalled.
// ----------------------------------------------------------------------------
module appliance_wash_cycle_sequencer #(
	parameter int COUNT_BITS = wcs_pkg::COUNT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	wcs_tick_if.sink                      tick,
	wcs_result_if.source                  result,
	input  logic                          cfg_we,
	input  logic [wcs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [wcs_pkg::CFG_W-1:0]     cfg_wdata
);
	import wcs_pkg::*;

	logic [TEMP_W-1:0] temp_threshold_q;
	logic [TPS_W-1:0]  ticks_per_second_q;
	tick_t             item_s1;
	logic              valid_s1;
	stage_ctl_t        ctl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_threshold_q   <= TEMP_THRESHOLD_RST;
			ticks_per_second_q <= TICKS_PER_SECOND_RST;
		end else if (cfg_we) begin
			if (cfg_index == CFG_TEMP_THRESHOLD) begin
				temp_threshold_q <= cfg_wdata[TEMP_W-1:0];
			end else if (cfg_index == CFG_TICKS_PER_SECOND) begin
				ticks_per_second_q <= cfg_wdata[TPS_W-1:0];
			end
		end
	end

	wcs_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.tick     (tick),
		.advance  (ctl.advance),
		.item_s1  (item_s1),
		.valid_s1 (valid_s1)
	);

	wcs_seq #(.COUNT_BITS(COUNT_BITS)) u_seq (
		.clk              (clk),
		.arst_n           (arst_n),
		.item_s1          (item_s1),
		.valid_s1         (valid_s1),
		.temp_threshold   (temp_threshold_q),
		.ticks_per_second (ticks_per_second_q),
		.result           (result),
		.ctl              (ctl)
	);

`ifndef ASSERT_OFF
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!tick.ready |-> (ctl.valid && result.valid && !result.ready))
		else $error("tick stalled without a full pipeline");

	a_fault_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.fault) |-> (result.phase == PHASE_CODE_IDLE &&
		!result.fill_valve && !result.motor_on && !result.drain_valve &&
		!result.cycle_done))
		else $error("fault result not idle with drives off");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.cycle_done) |-> (result.phase == PHASE_CODE_IDLE &&
		!result.motor_on && !result.drain_valve))
		else $error("cycle completion not in idle");

	a_advance_moves_item: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.advance |=> result.valid)
		else $error("advanced item lost before result register");
`endif
endmodule

>>> rtl/core/wcs_in_reg.sv
// ----------------------------------------------------------------------------
// wcs_in_reg
// Input register stage for tick items.
// ----------------------------------------------------------------------------
module wcs_in_reg (
	input  logic             clk,
	input  logic             arst_n,
	wcs_tick_if.sink         tick,
	input  logic             advance,
	output wcs_pkg::tick_t   item_s1,
	output logic             valid_s1
);
	import wcs_pkg::*;

	logic accept;

	assign tick.ready = !valid_s1 || advance;
	assign accept     = tick.valid && tick.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.door_closed     <= tick.door_closed;
			item_s1.temperature     <= tick.temperature;
			item_s1.program_buttons <= tick.program_buttons;
		end
	end
endmodule

>>> rtl/core/wcs_load.sv
// ----------------------------------------------------------------------------
// wcs_load
// Phase tick count: table seconds times ticks per second, saturated.
// ----------------------------------------------------------------------------
module wcs_load #(
	parameter int COUNT_BITS = wcs_pkg::COUNT_BITS_DEF
) (
	input  logic [wcs_pkg::PROG_W-1:0] prog,
	input  wcs_pkg::phase_t            ph,
	input  logic [wcs_pkg::TPS_W-1:0]  tps,
	output logic [COUNT_BITS-1:0]      count
);
	import wcs_pkg::*;

	localparam int PROD_W = SECS_W + TPS_W;
	localparam int EXT_W  = (COUNT_BITS > PROD_W) ? COUNT_BITS : PROD_W;

	logic [TPS_W-1:0]  tps_eff;
	logic [PROD_W-1:0] prod;
	logic [EXT_W-1:0]  prod_ext;
	logic [EXT_W-1:0]  cmax_ext;

	assign tps_eff  = (tps == '0) ? TPS_W'(1) : tps;
	assign prod     = PROD_W'(phase_secs(prog, ph)) * PROD_W'(tps_eff);
	assign prod_ext = EXT_W'(prod);
	assign cmax_ext = EXT_W'({COUNT_BITS{1'b1}});
	assign count    = (prod_ext > cmax_ext) ? {COUNT_BITS{1'b1}} : prod_ext[COUNT_BITS-1:0];
endmodule

>>> rtl/core/wcs_seq.sv
// ----------------------------------------------------------------------------
// wcs_seq
// Phase sequencer state and result register; one tick per advance.
// ----------------------------------------------------------------------------
module wcs_seq #(
	parameter int COUNT_BITS = wcs_pkg::COUNT_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  wcs_pkg::tick_t             item_s1,
	input  logic                       valid_s1,
	input  logic [wcs_pkg::TEMP_W-1:0] temp_threshold,
	input  logic [wcs_pkg::TPS_W-1:0]  ticks_per_second,
	wcs_result_if.source               result,
	output wcs_pkg::stage_ctl_t        ctl
);
	import wcs_pkg::*;

	phase_t                phase_q, phase_n;
	logic [PROG_W-1:0]     prog_q, prog_n, prog_sel;
	logic [COUNT_BITS-1:0] ticks_q, ticks_n, load_cnt;
	logic [PROG_W-1:0]     load_prog;
	phase_t                load_ph;
	logic                  fault, done;
	logic                  res_valid_q;
	logic [PHASE_W-1:0]    res_phase_q;
	logic                  res_fault_q, res_fill_q, res_motor_q, res_drain_q, res_done_q;

	assign ctl.valid   = valid_s1;
	assign ctl.advance = valid_s1 && (!res_valid_q || result.ready);

	always_comb begin
		priority if (item_s1.program_buttons[0]) prog_sel = PROG_1;
		else if (item_s1.program_buttons[1])     prog_sel = PROG_2;
		else if (item_s1.program_buttons[2])     prog_sel = PROG_3;
		else                                     prog_sel = PROG_NONE;
	end

	assign load_prog = (phase_q == PH_IDLE) ? prog_sel : prog_q;
	assign load_ph   = (phase_q == PH_IDLE) ? PH_FILL : next_phase(phase_q);

	wcs_load #(.COUNT_BITS(COUNT_BITS)) u_load (
		.prog  (load_prog),
		.ph    (load_ph),
		.tps   (ticks_per_second),
		.count (load_cnt)
	);

	assign fault = !item_s1.door_closed || (item_s1.temperature < temp_threshold);

	always_comb begin
		phase_n = phase_q;
		prog_n  = prog_q;
		ticks_n = ticks_q;
		done    = 1'b0;
		if (fault) begin
			phase_n = PH_IDLE;
			ticks_n = '0;
		end else begin
			unique case (phase_q)
				PH_IDLE: begin
					if (prog_sel != PROG_NONE) begin
						prog_n  = prog_sel;
						phase_n = PH_FILL;
						ticks_n = load_cnt;
					end
				end
				PH_FILL, PH_WASH, PH_DRY, PH_DRAIN: begin
					if (ticks_q > COUNT_BITS'(1)) begin
						ticks_n = ticks_q - COUNT_BITS'(1);
					end else if (phase_q == PH_DRAIN) begin
						phase_n = PH_IDLE;
						ticks_n = '0;
						done    = 1'b1;
					end else begin
						phase_n = load_ph;
						ticks_n = load_cnt;
					end
				end
				default: begin
					phase_n = PH_IDLE;
					ticks_n = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			prog_q      <= PROG_NONE;
			ticks_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (ctl.advance) begin
				phase_q <= phase_n;
				prog_q  <= prog_n;
				ticks_q <= ticks_n;
			end
			if (ctl.advance) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.advance) begin
			res_phase_q <= phase_code(phase_n);
			res_fault_q <= fault;
			res_fill_q  <= (phase_n == PH_FILL);
			res_motor_q <= (phase_n == PH_WASH) || (phase_n == PH_DRY) || (phase_n == PH_DRAIN);
			res_drain_q <= (phase_n == PH_DRAIN);
			res_done_q  <= done;
		end
	end

	assign result.valid       = res_valid_q;
	assign result.phase       = res_phase_q;
	assign result.fault       = res_fault_q;
	assign result.fill_valve  = res_fill_q;
	assign result.motor_on    = res_motor_q;
	assign result.drain_valve = res_drain_q;
	assign result.cycle_done  = res_done_q;
endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench of the wash cycle sequencer. Tick items are sent with random
// gaps while results are taken with random stalls. Each accepted tick is run
// through a local model of the phase sequencer, and every result is checked
// in order against the queued prediction.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import wcs_pkg::*;

	localparam int COUNT_W = COUNT_BITS_DEF;
	localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_W) - 1;
	localparam int GAP_PCT = 36;
	localparam int RX_HOLD_CYCLES = 40;
	localparam int SETTLE_CYCLES = 4;

	typedef struct packed {
		logic [PHASE_W-1:0] phase;
		logic               fault;
		logic               fill_valve;
		logic               motor_on;
		logic               drain_valve;
		logic               cycle_done;
	} drive_state_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_wdata;

	wcs_tick_if tick_ch ();
	wcs_result_if res_ch ();

	appliance_wash_cycle_sequencer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick      (tick_ch),
		.result    (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #6 clk = ~clk;

	// model state
	logic [TEMP_W-1:0]  temp_threshold = TEMP_THRESHOLD_RST;
	logic [TPS_W-1:0]   ticks_per_sec = TICKS_PER_SECOND_RST;
	logic [PHASE_W-1:0] model_phase = PHASE_CODE_IDLE;
	logic [PROG_W-1:0]  model_prog = PROG_NONE;
	logic [COUNT_W-1:0] model_ticks = '0;

	drive_state_t expected_drives[$];
	int mismatches = 0;
	bit tx_gaps = 1'b1;
	bit rx_gaps = 1'b1;
	logic rx_hold = 1'b0;
	event hold_off_req;

	function automatic logic [COUNT_W-1:0] phase_ticks(input logic [PROG_W-1:0] prog,
		input logic [PHASE_W-1:0] ph);
		longint unsigned secs;
		longint unsigned rate;
		longint unsigned n;
		secs = 0;
		case (prog)
			PROG_1: begin
				case (ph)
					PHASE_CODE_FILL:  secs = 1;
					PHASE_CODE_WASH:  secs = 10;
					PHASE_CODE_DRY:   secs = 5;
					PHASE_CODE_DRAIN: secs = 1;
					default:          secs = 0;
				endcase
			end
			PROG_2: begin
				case (ph)
					PHASE_CODE_FILL:  secs = 1;
					PHASE_CODE_WASH:  secs = 5;
					PHASE_CODE_DRY:   secs = 2;
					PHASE_CODE_DRAIN: secs = 3;
					default:          secs = 0;
				endcase
			end
			PROG_3: begin
				case (ph)
					PHASE_CODE_FILL:  secs = 1;
					PHASE_CODE_WASH:  secs = 5;
					PHASE_CODE_DRY:   secs = 3;
					PHASE_CODE_DRAIN: secs = 1;
					default:          secs = 0;
				endcase
			end
			default: secs = 0;
		endcase
		rate = (ticks_per_sec == '0) ? 1 : ticks_per_sec;
		n = secs * rate;
		if (n > COUNT_MAX)
			n = COUNT_MAX;
		return n[COUNT_W-1:0];
	endfunction

	function automatic drive_state_t sequence_tick(input logic door,
		input logic [TEMP_W-1:0] temp, input logic [BTN_W-1:0] btn);
		drive_state_t d;
		logic is_fault;
		logic done;
		is_fault = !door || (temp < temp_threshold);
		done = 1'b0;
		if (is_fault) begin
			model_phase = PHASE_CODE_IDLE;
			model_ticks = '0;
		end else if (model_phase == PHASE_CODE_IDLE) begin
			if (btn != '0) begin
				if (btn[0])
					model_prog = PROG_1;
				else if (btn[1])
					model_prog = PROG_2;
				else
					model_prog = PROG_3;
				model_phase = PHASE_CODE_FILL;
				model_ticks = phase_ticks(model_prog, PHASE_CODE_FILL);
			end
		end else if (model_phase > PHASE_CODE_DRAIN) begin
			model_phase = PHASE_CODE_IDLE;
			model_ticks = '0;
		end else if (model_ticks > 1) begin
			model_ticks = model_ticks - 1'b1;
		end else if (model_phase == PHASE_CODE_DRAIN) begin
			model_phase = PHASE_CODE_IDLE;
			model_ticks = '0;
			done = 1'b1;
		end else begin
			model_phase = model_phase + 1'b1;
			model_ticks = phase_ticks(model_prog, model_phase);
		end
		d.phase       = model_phase;
		d.fault       = is_fault;
		d.fill_valve  = (model_phase == PHASE_CODE_FILL);
		d.motor_on    = (model_phase >= PHASE_CODE_WASH) && (model_phase <= PHASE_CODE_DRAIN);
		d.drain_valve = (model_phase == PHASE_CODE_DRAIN);
		d.cycle_done  = done;
		return d;
	endfunction

	always @(posedge clk) begin
		if (arst_n && tick_ch.valid && tick_ch.ready)
			expected_drives.push_back(sequence_tick(tick_ch.door_closed,
				tick_ch.temperature, tick_ch.program_buttons));
	end

	always @(posedge clk) begin
		drive_state_t got;
		drive_state_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got = {res_ch.phase, res_ch.fault, res_ch.fill_valve, res_ch.motor_on,
				res_ch.drain_valve, res_ch.cycle_done};
			if (expected_drives.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result phase %0d", $realtime, got.phase);
			end else begin
				want = expected_drives.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: mismatch phase %0d/%0d fault %b/%b fill %b/%b %s %b/%b %b/%b %b/%b",
							$realtime, want.phase, got.phase, want.fault, got.fault,
							want.fill_valve, got.fill_valve, "motor/drain/done",
							want.motor_on, got.motor_on, want.drain_valve, got.drain_valve,
							want.cycle_done, got.cycle_done);
				end
			end
		end
	end

	always @(posedge clk)
		res_ch.ready <= !rx_hold && !(rx_gaps && ($urandom_range(99) < GAP_PCT));

	initial forever begin
		@(hold_off_req);
		rx_hold <= 1'b1;
		repeat (RX_HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	task automatic send_tick(input logic door, input logic [TEMP_W-1:0] temp,
		input logic [BTN_W-1:0] btn);
		if (tx_gaps) begin
			while ($urandom_range(99) < GAP_PCT) begin
				tick_ch.valid <= 1'b0;
				@(posedge clk);
			end
		end
		tick_ch.valid           <= 1'b1;
		tick_ch.door_closed     <= door;
		tick_ch.temperature     <= temp;
		tick_ch.program_buttons <= btn;
		@(posedge clk);
		while (!tick_ch.ready)
			@(posedge clk);
	endtask

	// healthy ticks, buttons at random
	task automatic send_good_ticks(input int n);
		repeat (n)
			send_tick(1'b1, 10'($urandom_range(1023, temp_threshold)),
				3'($urandom_range(7)));
	endtask

	task automatic settle();
		tick_ch.valid <= 1'b0;
		@(posedge clk);
		while (expected_drives.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_config(input logic [TEMP_W-1:0] thr, input logic [TPS_W-1:0] rate);
		settle();
		cfg_we    <= 1'b1;
		cfg_index <= CFG_TEMP_THRESHOLD;
		cfg_wdata <= thr;
		@(posedge clk);
		cfg_index <= CFG_TICKS_PER_SECOND;
		cfg_wdata <= rate;
		@(posedge clk);
		cfg_we <= 1'b0;
		temp_threshold = thr;
		ticks_per_sec  = rate;
	endtask

	task automatic test_reset_defaults();
		send_tick(1'b1, 10'd160, 3'd0);
		send_tick(1'b1, 10'd159, 3'd1);
		send_tick(1'b0, 10'h3FF, 3'd7);
		send_tick(1'b1, 10'd160, 3'd4);
		send_good_ticks(11);
		send_tick(1'b0, 10'd0, 3'd0);
		settle();
	endtask

	task automatic test_programs();
		write_config(TEMP_THRESHOLD_RST, 10'd1);
		send_tick(1'b1, 10'h3FF, 3'd7);
		send_good_ticks(16);
		send_tick(1'b1, 10'h3FF, 3'd6);
		send_good_ticks(10);
		send_tick(1'b1, 10'd600, 3'd4);
		send_good_ticks(9);
		settle();
	endtask

	task automatic test_fault_abort();
		// zero rate counts as one tick per second
		write_config(10'd0, 10'd0);
		send_tick(1'b1, 10'd0, 3'd2);
		send_good_ticks(8);
		send_tick(1'b0, 10'h3FF, 3'd1);
		send_tick(1'b1, 10'd5, 3'd1);
		send_good_ticks(3);
		write_config(10'h3FF, 10'd2);
		send_tick(1'b1, 10'd1022, 3'd1);
		send_tick(1'b1, 10'h3FF, 3'd1);
		send_good_ticks(40);
		send_tick(1'b1, 10'd1022, 3'd0);
		settle();
	endtask

	task automatic test_long_phases();
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		write_config(TEMP_THRESHOLD_RST, 10'd150);
		send_tick(1'b1, 10'd800, 3'd1);
		send_good_ticks(200);
		send_tick(1'b0, 10'd800, 3'd0);
		settle();
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
	endtask

	task automatic test_backpressure();
		write_config(TEMP_THRESHOLD_RST, 10'd1);
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		-> hold_off_req;
		send_good_ticks(30);
		settle();
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
	endtask

	task automatic test_random();
		logic [TEMP_W-1:0] thr;
		logic [TPS_W-1:0] rate;
		for (int p = 0; p < 5; p++) begin
			thr  = (p == 0) ? 10'd0 : 10'($urandom_range(600));
			rate = (p == 4) ? 10'd0 : 10'($urandom_range(3, 1));
			tx_gaps = (p != 1);
			rx_gaps = (p != 3);
			write_config(thr, rate);
			repeat (40) begin
				if ($urandom_range(99) >= 4)
					send_good_ticks(1);
				else if (thr == '0 || $urandom_range(1))
					send_tick(1'b0, 10'($urandom_range(1023)), 3'($urandom_range(7)));
				else
					send_tick(1'b1, 10'($urandom_range(thr - 1, 0)),
						3'($urandom_range(7)));
			end
		end
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
		settle();
	endtask

	initial begin
		arst_n                  = 1'b0;
		tick_ch.valid           = 1'b0;
		tick_ch.door_closed     = 1'b0;
		tick_ch.temperature     = '0;
		tick_ch.program_buttons = '0;
		res_ch.ready            = 1'b0;
		cfg_we                  = 1'b0;
		cfg_index               = CFG_TEMP_THRESHOLD;
		cfg_wdata               = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_programs();
		test_fault_abort();
		test_long_phases();
		test_backpressure();
		test_random();

		settle();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && expected_drives.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#(5_000_000);
		$display("Test completed with failures");
		$finish;
	end

endmodule

>>> files.f
rtl/core/wcs_pkg.sv
rtl/core/wcs_tick_if.sv
rtl/core/wcs_result_if.sv
rtl/core/wcs_in_reg.sv
rtl/core/wcs_load.sv
rtl/core/wcs_seq.sv
rtl/core/appliance_wash_cycle_sequencer.sv
bench/tb.sv
